// ===== rtl/core/vfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vfu_pkg;

   // Field limits and component width
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COMP_BITS  = 16;

   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam int COORD_W   = 11;
   localparam int OUT_W     = COMP_BITS + 1;
   localparam int SUM_W     = COMP_BITS + 2;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int NUM_BLK   = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(64);
   localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(64);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FIELD_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FIELD_HEIGHT = CSR_IDX_W'(1);

   // Block kinds, in issue order
   localparam int BLK_INNER  = 0;  // source up and to the left
   localparam int BLK_BOTTOM = 1;  // source to the left, bottom row
   localparam int BLK_RIGHT  = 2;  // source above, right column
   localparam int BLK_CORNER = 3;  // source is this vector, bottom right

   // Beat positions within a block: bit 0 is column offset, bit 1 row offset
   localparam logic [1:0] BEAT_TL = 2'd0;
   localparam logic [1:0] BEAT_TR = 2'd1;
   localparam logic [1:0] BEAT_BL = 2'd2;
   localparam logic [1:0] BEAT_BR = 2'd3;

   typedef struct packed {
      logic signed [COMP_BITS-1:0] x;
      logic signed [COMP_BITS-1:0] y;
   } vec_type;

   // One classified input: its neighbourhood and the blocks it releases
   typedef struct packed {
      vec_type                ul;
      vec_type                up;
      vec_type                lf;
      vec_type                vc;
      logic [COL_W-1:0]       col;
      logic [ROW_W-1:0]       row;
      logic [NUM_BLK-1:0]     blk;
   } job_type;

   function automatic logic signed [OUT_W-1:0] blend(
      input logic [1:0]                  beat,
      input logic signed [COMP_BITS-1:0] p,
      input logic signed [COMP_BITS-1:0] r,
      input logic signed [COMP_BITS-1:0] d,
      input logic signed [COMP_BITS-1:0] q
   );
      logic signed [SUM_W-1:0] sum;
      logic signed [OUT_W-1:0] res;
      sum = SUM_W'(p) + SUM_W'(r) + SUM_W'(d) + SUM_W'(q);
      case (beat)
         BEAT_TL: res = {p, 1'b0};
         BEAT_TR: res = OUT_W'(p) + OUT_W'(r);
         BEAT_BL: res = OUT_W'(p) + OUT_W'(d);
         default: res = sum[SUM_W-1:1];
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vfu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vfu_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [vfu_pkg::COMP_BITS-1:0] req_vec_x,
   input  wire logic signed [vfu_pkg::COMP_BITS-1:0] req_vec_y,
   input  wire logic                                csr_write,
   input  wire logic [vfu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [vfu_pkg::CFG_W-1:0]           csr_data,
   output vfu_pkg::job_type                         job,
   output logic                                     push,
   input  wire logic                                q_full
);
   import vfu_pkg::*;

   localparam int CNT_W = COL_W + 1;
   localparam int RCNT_W = ROW_W + 1;

   logic [CFG_W-1:0]   width_ff, height_ff;
   logic [CNT_W-1:0]   w_eff;
   logic [RCNT_W-1:0]  h_eff;
   logic [COL_W-1:0]   w_last;
   logic [ROW_W-1:0]   h_last;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   vec_type            left_ff, left_in, ul_ff, ul_in;

   logic               s1_valid_ff, s1_valid_in;
   vec_type            s1_vec_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic [NUM_BLK-1:0] s1_blk_ff;
   vec_type            up_ff;

   vec_type            row_mem [MAX_WIDTH];

   vec_type            vec_now;
   logic [NUM_BLK-1:0] blk_now;
   logic               accept, s1_go, cfg_restart;
   logic               col_nz, row_nz, col_end, row_end;

   // Clamp the geometry to the supported range
   assign w_eff = (width_ff < CFG_W'(2)) ? CNT_W'(2) :
                  (int'(width_ff) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(width_ff);
   assign h_eff = (height_ff < CFG_W'(2)) ? RCNT_W'(2) :
                  (int'(height_ff) > MAX_HEIGHT) ? RCNT_W'(MAX_HEIGHT) : RCNT_W'(height_ff);
   assign w_last = COL_W'(w_eff - 1'b1);
   assign h_last = ROW_W'(h_eff - 1'b1);

   assign vec_now = '{x: req_vec_x, y: req_vec_y};

   // Classify by position: which blocks this vector completes
   assign col_nz  = (col_ff != '0);
   assign row_nz  = (row_ff != '0);
   assign col_end = (col_ff == w_last);
   assign row_end = (row_ff == h_last);
   always_comb begin
      blk_now             = '0;
      blk_now[BLK_INNER]  = col_nz && row_nz;
      blk_now[BLK_BOTTOM] = col_nz && row_end;
      blk_now[BLK_RIGHT]  = col_end && row_nz;
      blk_now[BLK_CORNER] = col_end && row_end;
   end

   assign s1_go     = s1_valid_ff && ((s1_blk_ff == '0) || !q_full);
   assign push      = s1_valid_ff && (s1_blk_ff != '0) && !q_full;
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   assign cfg_restart = csr_write &&
                        ((csr_index == REG_FIELD_WIDTH) || (csr_index == REG_FIELD_HEIGHT));

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : ROW_W'(row_ff + 1'b1);
         end else begin
            col_in = COL_W'(col_ff + 1'b1);
         end
      end
      left_in = cfg_restart ? '0 : (s1_go ? s1_vec_ff : left_ff);
      ul_in   = cfg_restart ? '0 : (s1_go ? up_ff : ul_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RESET_WIDTH;
         height_ff   <= RESET_HEIGHT;
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         ul_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_FIELD_WIDTH:  width_ff  <= csr_data;
               REG_FIELD_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         col_ff      <= col_in;
         row_ff      <= row_in;
         left_ff     <= left_in;
         ul_ff       <= ul_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Row store: read the vector above before overwriting it with this one
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_vec_ff       <= vec_now;
         s1_col_ff       <= col_ff;
         s1_row_ff       <= row_ff;
         s1_blk_ff       <= blk_now;
         up_ff           <= row_mem[col_ff];
         row_mem[col_ff] <= vec_now;
      end
   end

   assign job = '{ul: ul_ff, up: up_ff, lf: left_ff, vc: s1_vec_ff,
                  col: s1_col_ff, row: s1_row_ff, blk: s1_blk_ff};

   a_col_in_field: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last) else $error("column position beyond field width");
   a_row_in_field: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_last) else $error("row position beyond field height");

endmodule

`default_nettype wire

// ===== rtl/core/vfu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vfu_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire vfu_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output vfu_pkg::job_type      head,
   output logic                  head_valid
);
   import vfu_pkg::*;

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                empty;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = !empty;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full job queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty job queue");

endmodule

`default_nettype wire

// ===== rtl/core/vfu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vfu_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire vfu_pkg::job_type                  head,
   input  wire logic                              head_valid,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [vfu_pkg::COORD_W-1:0]            rsp_out_col,
   output logic [vfu_pkg::COORD_W-1:0]            rsp_out_row,
   output logic signed [vfu_pkg::OUT_W-1:0]       rsp_out_x,
   output logic signed [vfu_pkg::OUT_W-1:0]       rsp_out_y,
   output logic                                   rsp_run_last
);
   import vfu_pkg::*;

   logic [NUM_BLK-1:0] done_ff, done_in;
   logic [1:0]         beat_ff, beat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] col_ff, row_ff;
   logic signed [OUT_W-1:0] x_ff, y_ff;
   logic               last_ff;

   logic [NUM_BLK-1:0] remaining, cur_bit;
   logic               last_blk, emit, out_free;
   vec_type            p, r, d, q;
   logic [COL_W-1:0]   sx;
   logic [ROW_W-1:0]   sy;

   assign remaining = head.blk & ~done_ff;

   // Pick the earliest block still owed and its four neighbours
   always_comb begin
      cur_bit = '0;
      sx = head.col;
      sy = head.row;
      p  = head.vc;
      r  = head.vc;
      d  = head.vc;
      q  = head.vc;
      if (remaining[BLK_INNER]) begin
         cur_bit[BLK_INNER] = 1'b1;
         sx = COL_W'(head.col - 1'b1);
         sy = ROW_W'(head.row - 1'b1);
         p  = head.ul;
         r  = head.up;
         d  = head.lf;
      end else if (remaining[BLK_BOTTOM]) begin
         cur_bit[BLK_BOTTOM] = 1'b1;
         sx = COL_W'(head.col - 1'b1);
         p  = head.lf;
         d  = head.lf;
      end else if (remaining[BLK_RIGHT]) begin
         cur_bit[BLK_RIGHT] = 1'b1;
         sy = ROW_W'(head.row - 1'b1);
         p  = head.up;
         r  = head.up;
      end else if (remaining[BLK_CORNER]) begin
         cur_bit[BLK_CORNER] = 1'b1;
      end
   end

   assign last_blk = ((remaining & ~cur_bit) == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = head_valid && out_free;
   assign pop      = emit && (beat_ff == BEAT_BR) && last_blk;

   always_comb begin
      beat_in      = emit ? 2'(beat_ff + 1'b1) : beat_ff;
      done_in      = done_ff;
      if (emit && (beat_ff == BEAT_BR)) begin
         done_in = last_blk ? '0 : (done_ff | cur_bit);
      end
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         beat_ff      <= BEAT_TL;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register: load a fresh beat whenever the slot is free and a job waits
   always_ff @(posedge clock) begin
      if (emit) begin
         col_ff  <= COORD_W'({sx, beat_ff[0]});
         row_ff  <= COORD_W'({sy, beat_ff[1]});
         x_ff    <= blend(beat_ff, p.x, r.x, d.x, q.x);
         y_ff    <= blend(beat_ff, p.y, r.y, d.y, q.y);
         last_ff <= (beat_ff == BEAT_BR) && last_blk;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_col  = col_ff;
   assign rsp_out_row  = row_ff;
   assign rsp_out_x    = x_ff;
   assign rsp_out_y    = y_ff;
   assign rsp_run_last = last_ff;

   a_block_owed: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (remaining != '0)) else $error("queued job with no block left");
   a_mid_block_has_job: assert property (@(posedge clock) disable iff (reset)
      (beat_ff != BEAT_TL) |-> head_valid) else $error("block half issued without a job");

endmodule

`default_nettype wire

// ===== rtl/core/vector_field_upscale_2x_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 2x vector field upscaler. Vectors of a field_width x field_height field enter
// in raster order, one per req beat; each source vector p becomes four rsp beats
// in the doubled field: 2p, p+r, p+d and (p+r+d+q)>>1 (floor), where r, d and q
// are the right, lower and diagonal neighbours, replicated at the right and
// bottom edges. A block goes out as soon as its last neighbour has arrived, so
// the first row and first column produce nothing when they arrive, an inner
// vector releases one block (4 beats), a right-column or bottom-row vector two
// (8 beats), and the final vector of the field four (16 beats); run_last marks
// the final beat caused by an input. The front takes a req beat every cycle
// while a four-entry job queue has room; the back issues one rsp beat per cycle
// while a job is queued and rsp_stall allows, so a steady stream is limited by
// the single result port. Writing either geometry register restarts the field
// at the top-left; write only while idle. The row store needs no clearing after
// reset.

module vector_field_upscale_2x_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [vfu_pkg::COMP_BITS-1:0] req_vec_x,
   input  wire logic signed [vfu_pkg::COMP_BITS-1:0] req_vec_y,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [vfu_pkg::COORD_W-1:0]               rsp_out_col,
   output logic [vfu_pkg::COORD_W-1:0]               rsp_out_row,
   output logic signed [vfu_pkg::OUT_W-1:0]          rsp_out_x,
   output logic signed [vfu_pkg::OUT_W-1:0]          rsp_out_y,
   output logic                                      rsp_run_last,
   input  wire logic                                 csr_write,
   input  wire logic [vfu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [vfu_pkg::CFG_W-1:0]            csr_data
);
   import vfu_pkg::*;

   // Jobs travel front -> queue -> back
   job_type push_job, head;
   logic    push, q_full, pop, head_valid;

   // Front: take req beats, track position, read the vector above, classify
   vfu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_vec_x (req_vec_x),
      .req_vec_y (req_vec_y),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .job       (push_job),
      .push      (push),
      .q_full    (q_full)
   );

   // Queue: decouple the front from result back-pressure
   vfu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // Back: walk the owed blocks of each job, one rsp beat per cycle while a job waits and rsp_stall allows
   vfu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_col  (rsp_out_col),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_run_last (rsp_run_last)
   );

endmodule

`default_nettype wire
